// ===== rtl/process_state_queues_top_assert.svh =====
// Assertion helpers for the RTL top level.
`ifndef PROCESS_STATE_QUEUES_TOP_ASSERT_SVH
`define PROCESS_STATE_QUEUES_TOP_ASSERT_SVH

// Same-cycle implication.
`define PSQ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define PSQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/psq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package psq_pkg;

  localparam int LIST_DEPTH_DEF = 16;
  localparam int PID_BITS_DEF   = 16;

  localparam int REQ_W    = 3;
  localparam int PID_W    = 16;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  localparam logic [REQ_W-1:0] REQ_PUSH_TAIL  = 3'd0;
  localparam logic [REQ_W-1:0] REQ_PUSH_HEAD  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_RDY_TO_RUN = 3'd2;
  localparam logic [REQ_W-1:0] REQ_RUN_TO_FIN = 3'd3;
  localparam logic [REQ_W-1:0] REQ_KILL       = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOHIT = 2'd3;

  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic [PID_W-1:0] pid;
  } psq_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [PID_W-1:0]    moved_pid;
    logic                kill_hit;
    logic [COUNT_W-1:0]  ready_count;
    logic [COUNT_W-1:0]  running_count;
    logic [COUNT_W-1:0]  finished_count;
  } psq_rsp_t;

  // per-list command, shared by every cell of a list
  typedef struct packed {
    logic push_tail;
    logic push_head;
    logic pop_head;
    logic kill;
  } psq_cmd_t;

endpackage
`default_nettype wire

// ===== rtl/psq_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
module psq_cell import psq_pkg::*; #(
  parameter int WIDTH = PID_BITS_DEF
) (
  input  wire logic             clk,
  input  wire psq_cmd_t         cmd,
  input  wire logic             occ,
  input  wire logic             at_tail,
  input  wire logic [WIDTH-1:0] value,
  input  wire logic [WIDTH-1:0] left,
  input  wire logic [WIDTH-1:0] right,
  input  wire logic             hit_in,
  output logic                  hit_out,
  output logic [WIDTH-1:0]      entry
);

  logic match;
  logic close_gap;

  assign match     = occ && (entry == value);
  assign hit_out   = hit_in || match;
  // this cell and all after the first match pull from the right
  assign close_gap = cmd.kill && (hit_in || match);

  always_ff @(posedge clk) begin
    if (cmd.push_head) begin
      entry <= left;
    end else if (cmd.pop_head || close_gap) begin
      entry <= right;
    end else if (cmd.push_tail && at_tail) begin
      entry <= value;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/psq_list.sv =====
`timescale 1ns / 1ps
`default_nettype none
module psq_list import psq_pkg::*; #(
  parameter int DEPTH = LIST_DEPTH_DEF,
  parameter int WIDTH = PID_BITS_DEF,
  localparam int CW   = $clog2(DEPTH + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire psq_cmd_t         cmd,
  input  wire logic [WIDTH-1:0] value,
  output logic [CW-1:0]         fill,
  output logic [CW-1:0]         fill_next,
  output logic [WIDTH-1:0]      head,
  output logic                  hit
);

  logic [WIDTH-1:0] entry   [DEPTH];
  logic [WIDTH-1:0] left_d  [DEPTH];
  logic [WIDTH-1:0] right_d [DEPTH];
  logic [DEPTH:0]   chain;
  logic             grow;
  logic             shrink;

  assign chain[0] = 1'b0;
  assign hit      = chain[DEPTH];
  assign head     = entry[0];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign left_d[i] = value;
    end else begin : g_mid_l
      assign left_d[i] = entry[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_d[i] = '0;
    end else begin : g_mid_r
      assign right_d[i] = entry[i+1];
    end

    psq_cell #(.WIDTH(WIDTH)) u_cell (
      .clk     (clk),
      .cmd     (cmd),
      .occ     (CW'(i) < fill),
      .at_tail (fill == CW'(i)),
      .value   (value),
      .left    (left_d[i]),
      .right   (right_d[i]),
      .hit_in  (chain[i]),
      .hit_out (chain[i+1]),
      .entry   (entry[i])
    );
  end

  assign grow      = cmd.push_tail || cmd.push_head;
  assign shrink    = cmd.pop_head || (cmd.kill && hit);
  assign fill_next = fill + CW'(grow) - CW'(shrink);

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else begin
      fill <= fill_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/process_state_queues_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel  Role    Handshake            Payload
// req      input   req_valid/req_stall  psq_req_t (req_type, pid)
// rsp      output  rsp_valid/rsp_stall  psq_rsp_t (status, moved_pid, kill_hit, counts)
//
// One request per cycle while req_stall is low; its result beat appears in the cycle after acceptance.
// The ready-list match chain through the cells (kill search) sets the cycle time.
// Reset clears the three fill counts; list entries are not cleared, no sweep.
// req_stall is high only while a result waits in the output register under rsp_stall.
module process_state_queues_top import psq_pkg::*; #(
  parameter int LIST_DEPTH = LIST_DEPTH_DEF,
  parameter int PID_BITS   = PID_BITS_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     req_valid,
  output logic          req_stall,
  input  wire psq_req_t req,
  output logic          rsp_valid,
  input  wire logic     rsp_stall,
  output psq_rsp_t      rsp
);

`include "process_state_queues_top_assert.svh"

  localparam int CW = $clog2(LIST_DEPTH + 1);

  logic                rd_hit;
  logic                acc;
  logic [PID_BITS-1:0] key;
  logic [PID_BITS-1:0] rd_head, rn_head, fn_head;
  logic [CW-1:0]       rd_fill, rn_fill, fn_fill;
  logic [CW-1:0]       rd_fill_next, rn_fill_next, fn_fill_next;
  logic                rn_hit, fn_hit;
  psq_cmd_t            rd_cmd, rn_cmd, fn_cmd;
  logic [STATUS_W-1:0] status;
  logic [PID_BITS-1:0] moved;
  logic                hit;
  logic                rd_full, rd_empty, rn_full, rn_empty, fn_full;
  logic [CW+1:0]       total;

  assign req_stall = rsp_valid && rsp_stall;
  assign acc       = req_valid && !req_stall;
  assign key       = PID_BITS'(req.pid);

  assign rd_full  = rd_fill == CW'(LIST_DEPTH);
  assign rn_full  = rn_fill == CW'(LIST_DEPTH);
  assign fn_full  = fn_fill == CW'(LIST_DEPTH);
  assign rd_empty = rd_fill == '0;
  assign rn_empty = rn_fill == '0;

  always_comb begin
    rd_cmd = '0;
    rn_cmd = '0;
    fn_cmd = '0;
    status = ST_OK;
    moved  = '0;
    hit    = 1'b0;
    case (req.req_type)
      REQ_PUSH_TAIL, REQ_PUSH_HEAD: begin
        if (rd_full) begin
          status = ST_FULL;
        end else if (req.req_type == REQ_PUSH_TAIL) begin
          rd_cmd.push_tail = acc;
        end else begin
          rd_cmd.push_head = acc;
        end
      end
      REQ_RDY_TO_RUN: begin
        if (rd_empty) begin
          status = ST_EMPTY;
        end else if (rn_full) begin
          status = ST_FULL;
        end else begin
          rd_cmd.pop_head  = acc;
          rn_cmd.push_tail = acc;
          moved            = rd_head;
        end
      end
      REQ_RUN_TO_FIN: begin
        if (rn_empty) begin
          status = ST_EMPTY;
        end else if (fn_full) begin
          status = ST_FULL;
        end else begin
          rn_cmd.pop_head  = acc;
          fn_cmd.push_tail = acc;
          moved            = rn_head;
        end
      end
      REQ_KILL: begin
        rd_cmd.kill = acc;
        if (rd_hit) begin
          moved = key;
          hit   = 1'b1;
        end else if (rn_empty) begin
          status = ST_EMPTY;
        end else if (fn_full) begin
          status = ST_FULL;
        end else begin
          rn_cmd.pop_head  = acc;
          fn_cmd.push_tail = acc;
          moved            = rn_head;
          status           = ST_NOHIT;
        end
      end
      default: begin
      end
    endcase
  end

  psq_list #(.DEPTH(LIST_DEPTH), .WIDTH(PID_BITS)) u_ready (
    .clk       (clk),
    .rst       (rst),
    .cmd       (rd_cmd),
    .value     (key),
    .fill      (rd_fill),
    .fill_next (rd_fill_next),
    .head      (rd_head),
    .hit       (rd_hit)
  );

  psq_list #(.DEPTH(LIST_DEPTH), .WIDTH(PID_BITS)) u_running (
    .clk       (clk),
    .rst       (rst),
    .cmd       (rn_cmd),
    .value     (rd_head),
    .fill      (rn_fill),
    .fill_next (rn_fill_next),
    .head      (rn_head),
    .hit       (rn_hit)
  );

  psq_list #(.DEPTH(LIST_DEPTH), .WIDTH(PID_BITS)) u_finished (
    .clk       (clk),
    .rst       (rst),
    .cmd       (fn_cmd),
    .value     (rn_head),
    .fill      (fn_fill),
    .fill_next (fn_fill_next),
    .head      (fn_head),
    .hit       (fn_hit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else begin
      rsp_valid <= acc || (rsp_valid && rsp_stall);
    end
    if (acc) begin
      rsp.status         <= status;
      rsp.moved_pid      <= PID_W'(moved);
      rsp.kill_hit       <= hit;
      rsp.ready_count    <= COUNT_W'(rd_fill_next);
      rsp.running_count  <= COUNT_W'(rn_fill_next);
      rsp.finished_count <= COUNT_W'(fn_fill_next);
    end
  end

  assign total = (CW+2)'(rd_fill) + (CW+2)'(rn_fill) + (CW+2)'(fn_fill);

  `PSQ_ASSERT_NOW(a_fill_bound, clk, rst, 1'b1, (rd_fill <= CW'(LIST_DEPTH)) && (rn_fill <= CW'(LIST_DEPTH)) && (fn_fill <= CW'(LIST_DEPTH)), "list fill above depth")
  `PSQ_ASSERT_NEXT(a_kill_shrinks, clk, rst, acc && (req.req_type == REQ_KILL) && rd_hit, rd_fill == ($past(rd_fill) - CW'(1)), "kill hit did not shrink ready")
  `PSQ_ASSERT_NEXT(a_moves_keep_total, clk, rst, acc && ((req.req_type == REQ_RDY_TO_RUN) || (req.req_type == REQ_RUN_TO_FIN) || ((req.req_type == REQ_KILL) && !rd_hit)), total == $past(total), "move changed entry total")
  `PSQ_ASSERT_NOW(a_no_stray_hit, clk, rst, (fn_cmd.kill || rn_cmd.kill), 1'b0 && rn_hit && fn_hit && (fn_head == fn_head), "kill issued to running or finished")

endmodule
`default_nettype wire
